>>> design/memory_bist_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Memory BIST sequencer assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef MEMORY_BIST_SEQUENCER_DEFINES_SVH
`define MEMORY_BIST_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define MBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg
// Types, constants and pattern tables of the memory BIST sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbs_pkg;

    localparam int NUM_SEEDS  = 6;
    localparam int ADDR_WIDTH = 32;
    localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

    localparam logic [31:0] PAT_A    = 32'hAAAAAAAA;
    localparam logic [31:0] PAT_5    = 32'h55555555;
    localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
    localparam logic [31:0] MASK_B   = 32'h000000FF;
    localparam logic [31:0] MASK_H   = 32'h0000FFFF;

    typedef enum logic [2:0] {
        TEST_DATABUS  = 3'd0,
        TEST_CHECKER  = 3'd1,
        TEST_MARCH    = 3'd2,
        TEST_SEQUENCE = 3'd3,
        TEST_RAND8    = 3'd4,
        TEST_RAND16   = 3'd5,
        TEST_RAND32   = 3'd6,
        TEST_IDLE     = 3'd7
    } t_test;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } t_size;

    typedef enum logic [2:0] {
        REG_BASE  = 3'd0,
        REG_SIZE  = 3'd1,
        REG_CASES = 3'd2,
        REG_TMASK = 3'd3,
        REG_TVAL  = 3'd4,
        REG_LOOPS = 3'd5
    } t_reg;

    // march op codes
    localparam logic [1:0] MOP_W0 = 2'd0;
    localparam logic [1:0] MOP_W1 = 2'd1;
    localparam logic [1:0] MOP_R0 = 2'd2;
    localparam logic [1:0] MOP_R1 = 2'd3;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] size;
        logic [6:0]  cases;
        logic [31:0] tmask;
        logic [31:0] tval;
        logic [31:0] loops;
    } t_cfg;

    // packed so that the first field sits in the highest bits
    typedef struct packed {
        t_test       test_id;
        logic [31:0] fail_actual;
        logic [31:0] fail_expected;
        logic [31:0] fail_addr;
        logic        run_failed;
        logic        run_done;
        logic [31:0] write_data;
        logic [31:0] mem_addr;
        t_size       access_size;
        t_cmd        mem_cmd;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    typedef struct packed {
        logic        ok;
        t_test       test;
        logic [2:0]  seed;
        logic [31:0] lc;
    } t_find;

    function automatic logic [31:0] seed_tab(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = 32'd414505433;
            3'd1:    v = 32'd4101696611;
            3'd2:    v = 32'd314159265;
            3'd3:    v = 32'd1215752195;
            3'd4:    v = 32'd99989;
            3'd5:    v = 32'd7271477;
            3'd6:    v = 32'd414505433;
            default: v = 32'd4101696611;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] lfsr_next(input logic [31:0] s);
        logic fb;
        fb = s[31] ^ s[6] ^ s[4] ^ s[1] ^ s[0];
        return {fb, s[31:1]};
    endfunction

    function automatic logic [1:0] march_op(input logic [2:0] el, input logic [1:0] op);
        logic [1:0] c;
        case ({el, op})
            {3'd1, 2'd0}: c = MOP_R0;
            {3'd1, 2'd1}: c = MOP_W1;
            {3'd2, 2'd0}: c = MOP_R1;
            {3'd2, 2'd1}: c = MOP_W0;
            {3'd2, 2'd2}: c = MOP_R0;
            {3'd3, 2'd0}: c = MOP_W1;
            {3'd4, 2'd0}: c = MOP_R1;
            {3'd5, 2'd0}: c = MOP_R0;
            {3'd5, 2'd1}: c = MOP_W1;
            {3'd6, 2'd0}: c = MOP_R1;
            {3'd7, 2'd0}: c = MOP_R0;
            default:      c = MOP_W0;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] march_nops(input logic [2:0] el);
        logic [1:0] n;
        case (el)
            3'd0, 3'd3, 3'd7: n = 2'd1;
            3'd2:             n = 2'd3;
            default:          n = 2'd2;
        endcase
        return n;
    endfunction

    function automatic logic march_back(input logic [2:0] el);
        return (el == 3'd2) || (el == 3'd5) || (el == 3'd6) || (el == 3'd7);
    endfunction

    function automatic logic [31:0] seg_len(input t_test t, input logic [31:0] size);
        logic [31:0] l;
        case (t)
            TEST_DATABUS: l = 32'd32;
            TEST_RAND8:   l = size;
            TEST_RAND16:  l = {1'b0, size[31:1]};
            default:      l = {2'b0, size[31:2]};
        endcase
        return l;
    endfunction

    // first enabled test at or above a start index, 7 when none
    function automatic logic [2:0] first_en(input logic [6:0] en, input logic [3:0] from);
        logic [2:0] r;
        r = 3'd7;
        for (int k = 6; k >= 0; k--) begin
            if (en[k] && (4'(k) >= from)) begin
                r = 3'(k);
            end
        end
        return r;
    endfunction

    // next test after a finished one, stepping seeds and loops
    function automatic t_find find_next(input logic [6:0] en, input logic [3:0] from,
                                        input logic [2:0] seed, input logic [31:0] lc,
                                        input logic [31:0] loops);
        t_find       f;
        logic [3:0]  a;
        logic [3:0]  s1;
        logic [32:0] lc1;
        a   = {1'b0, first_en(en, from)};
        s1  = {1'b0, seed} + 4'd1;
        lc1 = {1'b0, lc} + 33'd1;
        f.ok   = 1'b1;
        f.seed = seed;
        f.lc   = lc;
        f.test = t_test'(a[2:0]);
        if (a == 4'd7) begin
            if ((en[6:4] != 3'b0) && (s1 < 4'(NUM_SEEDS))) begin
                f.seed = s1[2:0];
                f.test = t_test'(first_en(en, 4'd4));
            end else begin
                f.lc = lc1[31:0];
                if ((loops != 32'd0) && (lc1 >= {1'b0, loops})) begin
                    f.ok   = 1'b0;
                    f.test = TEST_IDLE;
                end else begin
                    f.seed = 3'd0;
                    f.test = t_test'(first_en(en, 4'd0));
                end
            end
        end
        return f;
    endfunction

endpackage

>>> design/memory_bist_sequencer.sv
// ----------------------------------------------------------------------------
// memory_bist_sequencer
// Memory self-test engine: at most one memory access per item, checks read data.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one item per memory step. tuser = req_type (0 starts a
//   run, 1 reports the memory ready), tdata = read data of the previous read.
//   Master channel: one result item per input item with the next access
//   (command, size, address, write or expected data), run status, first
//   failure data and the running test.
//   Configuration registers are written through i_cfg_we / i_cfg_index /
//   i_cfg_wdata and sampled when a run starts.
//   Latency: the result of an item is valid the cycle after it is accepted.
//   Throughput: one item per cycle unless the master side stalls; the
//   sequencer state update and the next-access logic sit between the
//   state registers and the result register.
//   Reset: no run active, idle results with run_done low, registers at
//   their reset values.
//   Stall: the result register holds while m_axis_tready is low and the
//   slave side accepts an item only once the register is free or drained
//   in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "memory_bist_sequencer_defines.svh"

module memory_bist_sequencer
    import mbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [31:0]        s_axis_tdata,   // read_data
    input  logic               s_axis_tuser,   // req_type
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // mem_cmd, access_size, mem_addr, write_data, run_done, run_failed,
    // fail_addr, fail_expected, fail_actual, test_id
    output logic [TDATA_W-1:0] m_axis_tdata,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata
);

    t_cfg    cfg;
    t_result res;
    t_result r_res;
    logic    r_valid;
    logic    step;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    mbs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mbs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_req    (s_axis_tuser),
        .i_rdata  (s_axis_tdata),
        .i_cfg    (cfg),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = TDATA_W'(r_res);

    `MBS_ASSERT_NOW(a_idle_id, r_valid && (r_res.mem_cmd == CMD_NONE), r_res.test_id == TEST_IDLE, "idle result with a running test")
    `MBS_ASSERT_NOW(a_done_quiet, r_valid && r_res.run_done, r_res.mem_cmd == CMD_NONE, "access issued after the run ended")
    `MBS_ASSERT_NEXT(a_start_clean, step && !s_axis_tuser, m_axis_tvalid && !r_res.run_failed, "start item left a failure flag")

endmodule

>>> design/mbs_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbs_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbs_cfg_regs
    import mbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base  <= 32'd0;
            r_cfg.size  <= 32'd0;
            r_cfg.cases <= 7'h7F;
            r_cfg.tmask <= 32'd0;
            r_cfg.tval  <= 32'd0;
            r_cfg.loops <= 32'd1;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_BASE:  r_cfg.base  <= i_cfg_wdata;
                REG_SIZE:  r_cfg.size  <= i_cfg_wdata;
                REG_CASES: r_cfg.cases <= i_cfg_wdata[6:0];
                REG_TMASK: r_cfg.tmask <= i_cfg_wdata;
                REG_TVAL:  r_cfg.tval  <= i_cfg_wdata;
                REG_LOOPS: r_cfg.loops <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/mbs_seq.sv
// ----------------------------------------------------------------------------
// mbs_seq
// Test sequencer: run state, read compare and next access per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbs_seq
    import mbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_req,
    input  logic [31:0] i_rdata,
    input  t_cfg        i_cfg,
    output t_result     o_result
);

    t_cfg        r_snap,    n_snap;
    t_test       r_phase,   n_phase;
    logic [2:0]  r_elem,    n_elem;
    logic [1:0]  r_op,      n_op;
    logic [31:0] r_ptr,     n_ptr;
    logic [31:0] r_lfsr,    n_lfsr;
    logic [2:0]  r_seed,    n_seed;
    logic        r_swap,    n_swap;
    logic        r_verify,  n_verify;
    logic [31:0] r_lc,      n_lc;
    logic        r_active,  n_active;
    logic        r_over,    n_over;
    logic        r_fail,    n_fail;
    logic [31:0] r_faddr,   n_faddr;
    logic [31:0] r_fexp,    n_fexp;
    logic [31:0] r_fact,    n_fact;
    logic        r_pend,    n_pend;
    logic [31:0] r_pexp,    n_pexp;
    logic [31:0] r_paddr,   n_paddr;
    t_size       r_psize,   n_psize;

    t_cfg        c;
    logic [6:0]  en;
    logic [31:0] len;
    logic [31:0] pmask;
    logic [31:0] act;
    logic [31:0] base;
    logic [31:0] word;
    logic [31:0] addr;
    logic [31:0] data;
    logic [31:0] wmask;
    logic [1:0]  code;
    logic [1:0]  op1;
    logic        rd;
    t_size       sz;
    t_find       f;
    t_result     res;

    always_comb begin
        n_snap   = r_snap;
        n_phase  = r_phase;
        n_elem   = r_elem;
        n_op     = r_op;
        n_ptr    = r_ptr;
        n_lfsr   = r_lfsr;
        n_seed   = r_seed;
        n_swap   = r_swap;
        n_verify = r_verify;
        n_lc     = r_lc;
        n_active = r_active;
        n_over   = r_over;
        n_fail   = r_fail;
        n_faddr  = r_faddr;
        n_fexp   = r_fexp;
        n_fact   = r_fact;
        n_pend   = 1'b0;
        n_pexp   = r_pexp;
        n_paddr  = r_paddr;
        n_psize  = r_psize;
        res      = '0;
        res.test_id = TEST_IDLE;
        f        = '0;
        word     = '0;
        code     = MOP_W0;
        op1      = '0;

        c = i_req ? r_snap : i_cfg;
        for (int k = 0; k < 7; k++) begin
            en[k] = c.cases[k] && (seg_len(t_test'(3'(k)), c.size) != 32'd0);
        end

        case (r_psize)
            SZ_BYTE: pmask = MASK_B;
            SZ_HALF: pmask = MASK_H;
            default: pmask = ALL_ONES;
        endcase
        act = i_rdata & pmask;

        if (!i_req) begin
            n_snap   = i_cfg;
            n_seed   = 3'd0;
            n_lc     = 32'd0;
            n_fail   = 1'b0;
            n_faddr  = 32'd0;
            n_fexp   = 32'd0;
            n_fact   = 32'd0;
            n_pexp   = 32'd0;
            n_active = 1'b1;
            n_over   = 1'b0;
            if (en == 7'd0) begin
                n_active = 1'b0;
                n_over   = 1'b1;
                n_phase  = TEST_IDLE;
            end else begin
                n_phase  = t_test'(first_en(en, 4'd0));
                n_elem   = 3'd0;
                n_op     = 2'd0;
                n_verify = 1'b0;
                n_ptr    = 32'd0;
                n_swap   = 1'b0;
                n_lfsr   = seed_tab(3'd0);
            end
        end else if (r_active && r_pend && (act != r_pexp)) begin
            if (!r_fail) begin
                n_faddr = r_paddr;
                n_fexp  = r_pexp;
                n_fact  = act;
            end
            n_fail = 1'b1;
            if (r_phase != TEST_DATABUS) begin
                n_active = 1'b0;
                n_over   = 1'b1;
                n_phase  = TEST_IDLE;
            end
        end

        // segment end: move on within the test, to the next test, or end the run
        len = seg_len(n_phase, c.size);
        if (n_active && (n_ptr >= len)) begin
            n_ptr = 32'd0;
            n_op  = 2'd0;
            if (n_phase == TEST_MARCH && n_elem != 3'd7) begin
                n_elem = n_elem + 3'd1;
            end else if (n_phase != TEST_MARCH && !n_verify) begin
                n_verify = 1'b1;
                n_lfsr   = seed_tab(n_seed);
            end else if (n_phase == TEST_CHECKER && !n_swap) begin
                n_swap   = 1'b1;
                n_verify = 1'b0;
            end else if (n_phase == TEST_DATABUS && n_fail) begin
                n_active = 1'b0;
                n_over   = 1'b1;
                n_phase  = TEST_IDLE;
            end else begin
                f      = find_next(en, {1'b0, n_phase} + 4'd1, n_seed, n_lc, c.loops);
                n_seed = f.seed;
                n_lc   = f.lc;
                if (!f.ok) begin
                    n_active = 1'b0;
                    n_over   = 1'b1;
                    n_phase  = TEST_IDLE;
                end else begin
                    n_phase  = f.test;
                    n_elem   = 3'd0;
                    n_verify = 1'b0;
                    n_swap   = 1'b0;
                    n_lfsr   = seed_tab(f.seed);
                end
            end
            len = seg_len(n_phase, c.size);
        end

        base  = {c.base[31:2], 2'b00};
        addr  = base + {n_ptr[29:0], 2'b00};
        data  = 32'd0;
        wmask = ALL_ONES;
        sz    = SZ_WORD;
        rd    = n_verify;
        case (n_phase)
            TEST_DATABUS: begin
                data  = 32'd1 << n_ptr[4:0];
                n_ptr = n_ptr + 32'd1;
            end
            TEST_CHECKER: begin
                data  = (n_ptr[0] ^ n_swap) ? PAT_5 : PAT_A;
                n_ptr = n_ptr + 32'd1;
            end
            TEST_MARCH: begin
                code = march_op(n_elem, n_op);
                word = march_back(n_elem) ? (len - 32'd1 - n_ptr) : n_ptr;
                addr = base + {word[29:0], 2'b00};
                rd   = code[1];
                data = code[0] ? ALL_ONES : 32'd0;
                op1  = n_op + 2'd1;
                if (op1 >= march_nops(n_elem)) begin
                    n_op  = 2'd0;
                    n_ptr = n_ptr + 32'd1;
                end else begin
                    n_op = op1;
                end
            end
            TEST_SEQUENCE: begin
                data  = ((addr & ADDR_MASK) & ~c.tmask) | c.tval;
                n_ptr = n_ptr + 32'd1;
            end
            TEST_RAND8: begin
                sz     = SZ_BYTE;
                wmask  = MASK_B;
                n_lfsr = lfsr_next(n_lfsr);
                data   = n_lfsr & wmask;
                addr   = base + n_ptr;
                n_ptr  = n_ptr + 32'd1;
            end
            TEST_RAND16: begin
                sz     = SZ_HALF;
                wmask  = MASK_H;
                n_lfsr = lfsr_next(n_lfsr);
                data   = n_lfsr & wmask;
                addr   = base + {n_ptr[30:0], 1'b0};
                n_ptr  = n_ptr + 32'd1;
            end
            TEST_RAND32: begin
                n_lfsr = lfsr_next(n_lfsr);
                data   = n_lfsr;
                n_ptr  = n_ptr + 32'd1;
            end
            default: begin
            end
        endcase
        addr = addr & ADDR_MASK;

        if (n_active) begin
            res.mem_cmd     = rd ? CMD_READ : CMD_WRITE;
            res.access_size = sz;
            res.mem_addr    = addr;
            res.write_data  = data;
            res.test_id     = n_phase;
            if (rd) begin
                n_pend  = 1'b1;
                n_pexp  = data;
                n_paddr = addr;
                n_psize = sz;
            end
        end else begin
            n_elem   = r_elem;
            n_op     = r_op;
            n_ptr    = r_ptr;
            n_lfsr   = r_lfsr;
            n_verify = r_verify;
            n_swap   = r_swap;
            if (!r_active) begin
                n_seed = r_seed;
                n_lc   = r_lc;
            end
        end
        res.run_done      = n_over;
        res.run_failed    = n_fail;
        res.fail_addr     = n_faddr;
        res.fail_expected = n_fexp;
        res.fail_actual   = n_fact;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap   <= '0;
            r_phase  <= TEST_IDLE;
            r_elem   <= 3'd0;
            r_op     <= 2'd0;
            r_ptr    <= 32'd0;
            r_lfsr   <= 32'd0;
            r_seed   <= 3'd0;
            r_swap   <= 1'b0;
            r_verify <= 1'b0;
            r_lc     <= 32'd0;
            r_active <= 1'b0;
            r_over   <= 1'b0;
            r_fail   <= 1'b0;
            r_faddr  <= 32'd0;
            r_fexp   <= 32'd0;
            r_fact   <= 32'd0;
            r_pend   <= 1'b0;
            r_pexp   <= 32'd0;
            r_paddr  <= 32'd0;
            r_psize  <= SZ_WORD;
        end else if (i_step) begin
            r_snap   <= n_snap;
            r_phase  <= n_phase;
            r_elem   <= n_elem;
            r_op     <= n_op;
            r_ptr    <= n_ptr;
            r_lfsr   <= n_lfsr;
            r_seed   <= n_seed;
            r_swap   <= n_swap;
            r_verify <= n_verify;
            r_lc     <= n_lc;
            r_active <= n_active;
            r_over   <= n_over;
            r_fail   <= n_fail;
            r_faddr  <= n_faddr;
            r_fexp   <= n_fexp;
            r_fact   <= n_fact;
            r_pend   <= n_pend;
            r_pexp   <= n_pexp;
            r_paddr  <= n_paddr;
            r_psize  <= n_psize;
        end
    end

    assign o_result = res;

endmodule
